### sv/prq_pkg.sv
package prq_pkg;

  localparam int unsigned KEY_W  = 16;
  localparam int unsigned PRIO_W = 8;
  localparam int unsigned OCC_W  = 5;

  typedef enum logic [1:0] {
    OP_INS_PRIO = 2'd0,
    OP_INS_TAIL = 2'd1,
    OP_FIND     = 2'd2,
    OP_REMOVE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_MISSING = 2'd1,
    STATUS_FULL    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHUP_RD,
    S_SHUP_WR,
    S_SHDN_RD,
    S_SHDN_WR
  } ctrl_state_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC,
    IDX_COUNT
  } idx_op_e;

  typedef enum logic [1:0] {
    POS_HOLD,
    POS_IDX,
    POS_COUNT
  } pos_op_e;

  typedef enum logic [1:0] {
    RD_IDX,
    RD_IDX_M1,
    RD_IDX_P1
  } rd_sel_e;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic    req_load;
    idx_op_e idx_op;
    pos_op_e pos_op;
    rd_sel_e rd_sel;
    logic    wr_new;
    logic    wr_shift;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    found_load;
    logic    status_load;
    status_e status_val;
    logic    out_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_e  op;
    logic empty;
    logic full;
    logic hit;
    logic last;
    logic at_pos;
    logic out_free;
  } dp_sts_t;

endpackage

### sv/priority_ready_queue_unit.sv
// Channel | Direction | Handshake                 | Word
// --------+-----------+---------------------------+-----------------------------------------
// in      | input     | in_valid_i / in_stall_o   | operation_i, key_i, priority_req_i
// out     | output    | out_valid_o / out_stall_i | status_o, found_priority_o, occupancy_o
//
// One word in, one result word out. Each entry scanned or moved through the entry RAM
// (registered read) takes a read step and a check or write step, plus a decide step and,
// for an insert, a final write; the longest runs are a remove or a priority insert at
// the head. A new word is taken only once the previous result has been loaded for output.
// Reset clears the occupancy, the output valid and the controller; the entry RAM is not.
// in_stall_o is high while an operation runs and while its result waits for the output.
module priority_ready_queue_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  operation_i,
  input  logic [prq_pkg::KEY_W-1:0]   key_i,
  input  logic [prq_pkg::PRIO_W-1:0]  priority_req_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [prq_pkg::PRIO_W-1:0]  found_priority_o,
  output logic [prq_pkg::OCC_W-1:0]   occupancy_o
);

  import prq_pkg::*;

  // Command and status between the sequencer and the entry datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer: scan, shift up for insert, shift down for remove
  prq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Entry RAM, walk index, insert position, occupancy and the result word
  prq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .operation_i      (operation_i),
    .key_i            (key_i),
    .priority_req_i   (priority_req_i),
    .out_stall_i      (out_stall_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .status_o         (status_o),
    .found_priority_o (found_priority_o),
    .occupancy_o      (occupancy_o)
  );

endmodule

### sv/prq_ram.sv
module prq_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/prq_datapath.sv
module prq_datapath #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [1:0]                  operation_i,
  input  logic [prq_pkg::KEY_W-1:0]   key_i,
  input  logic [prq_pkg::PRIO_W-1:0]  priority_req_i,
  input  logic                        out_stall_i,
  input  prq_pkg::dp_cmd_t            cmd_i,
  output prq_pkg::dp_sts_t            sts_o,
  output logic                        out_valid_o,
  output logic [1:0]                  status_o,
  output logic [prq_pkg::PRIO_W-1:0]  found_priority_o,
  output logic [prq_pkg::OCC_W-1:0]   occupancy_o
);

  import prq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  op_e               req_op_q;
  logic [KEY_W-1:0]  req_key_q;
  logic [PRIO_W-1:0] req_prio_q;
  status_e           res_status_q;
  logic [PRIO_W-1:0] res_found_q;

  logic [CW-1:0] count_q;
  logic [CW-1:0] count_d;
  logic [CW-1:0] idx_q;
  logic [CW-1:0] pos_q;
  logic [CW-1:0] idx_m1;
  logic [CW-1:0] idx_p1;

  logic              out_valid_q;
  logic [1:0]        out_status_q;
  logic [PRIO_W-1:0] out_found_q;
  logic [OCC_W-1:0]  out_occ_q;

  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  logic [AW-1:0] raddr;
  entry_t        rdata;
  entry_t        new_entry;

  assign idx_m1    = idx_q - CW'(1);
  assign idx_p1    = idx_q + CW'(1);
  assign new_entry = '{key: req_key_q, prio: req_prio_q};

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_IDX:    raddr = idx_q[AW-1:0];
      RD_IDX_M1: raddr = idx_m1[AW-1:0];
      RD_IDX_P1: raddr = idx_p1[AW-1:0];
      default:   raddr = idx_q[AW-1:0];
    endcase
  end

  assign we    = cmd_i.wr_new | cmd_i.wr_shift;
  assign waddr = cmd_i.wr_new ? pos_q[AW-1:0] : idx_q[AW-1:0];
  assign wdata = cmd_i.wr_new ? new_entry : rdata;

  prq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Status toward the controller
  always_comb begin
    sts_o.op       = req_op_q;
    sts_o.empty    = (count_q == '0);
    sts_o.full     = (count_q == CW'(DEPTH));
    sts_o.hit      = (req_op_q == OP_INS_PRIO) ? (rdata.prio < req_prio_q)
                                               : (rdata.key == req_key_q);
    sts_o.last     = ((CW+1)'(idx_q) + (CW+1)'(1)) == (CW+1)'(count_q);
    sts_o.at_pos   = (idx_q == pos_q);
    sts_o.out_free = !out_valid_q || !out_stall_i;
  end

  // Occupancy after this cycle's command
  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      req_op_q   <= op_e'(operation_i);
      req_key_q  <= key_i;
      req_prio_q <= priority_req_i;
    end

    if (cmd_i.req_load) begin
      res_status_q <= STATUS_OK;
    end else if (cmd_i.status_load) begin
      res_status_q <= cmd_i.status_val;
    end

    if (cmd_i.req_load) begin
      res_found_q <= '0;
    end else if (cmd_i.found_load) begin
      res_found_q <= rdata.prio;
    end

    unique case (cmd_i.idx_op)
      IDX_HOLD:  idx_q <= idx_q;
      IDX_ZERO:  idx_q <= '0;
      IDX_INC:   idx_q <= idx_p1;
      IDX_DEC:   idx_q <= idx_m1;
      IDX_COUNT: idx_q <= count_q;
      default:   idx_q <= idx_q;
    endcase

    unique case (cmd_i.pos_op)
      POS_HOLD:  pos_q <= pos_q;
      POS_IDX:   pos_q <= idx_q;
      POS_COUNT: pos_q <= count_q;
      default:   pos_q <= pos_q;
    endcase

    // Take status, priority and occupancy as they stand after the finishing step
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.status_load ? cmd_i.status_val : res_status_q;
      out_found_q  <= cmd_i.found_load ? rdata.prio : res_found_q;
      out_occ_q    <= OCC_W'(count_d);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign found_priority_o = out_found_q;
  assign occupancy_o      = out_occ_q;

  a_no_inc_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |-> (count_q < CW'(DEPTH)))
    else $error("entry count incremented on a full queue");

  a_no_dec_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_dec |-> (count_q != '0))
    else $error("entry count decremented on an empty queue");

  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> sts_o.out_free)
    else $error("result word overwritten while still stalled");

  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!cmd_i.cnt_inc && !cmd_i.cnt_dec) |=> $stable(count_q))
    else $error("entry count moved without a command");

endmodule

### sv/prq_ctrl.sv
module prq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  prq_pkg::dp_sts_t sts_i,
  output prq_pkg::dp_cmd_t cmd_o
);

  import prq_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        priority if ((sts_i.op == OP_INS_PRIO || sts_i.op == OP_INS_TAIL) && sts_i.full)
          state_d = S_IDLE;
        else if (sts_i.op == OP_INS_TAIL || (sts_i.op == OP_INS_PRIO && sts_i.empty))
          state_d = S_SHUP_RD;
        else if (sts_i.empty)
          state_d = S_IDLE;
        else
          state_d = S_SCAN_RD;
      end
      S_SCAN_RD: state_d = S_SCAN_CHK;
      S_SCAN_CHK: begin
        priority if (sts_i.hit) begin
          unique case (sts_i.op)
            OP_INS_PRIO, OP_INS_TAIL: state_d = S_SHUP_RD;
            OP_FIND:                  state_d = S_IDLE;
            OP_REMOVE:                state_d = S_SHDN_RD;
            default:                  state_d = S_IDLE;
          endcase
        end else if (sts_i.last) begin
          state_d = (sts_i.op == OP_INS_PRIO) ? S_SHUP_RD : S_IDLE;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_SHUP_RD: state_d = sts_i.at_pos ? S_IDLE : S_SHUP_WR;
      S_SHUP_WR: state_d = S_SHUP_RD;
      S_SHDN_RD: state_d = sts_i.last ? S_IDLE : S_SHDN_WR;
      S_SHDN_WR: state_d = S_SHDN_RD;
      default:   state_d = S_IDLE;
    endcase
    // Hold the finished result until the output word is free
    if (state_d == S_IDLE && state_q != S_IDLE && !sts_i.out_free) begin
      state_d = state_q;
    end
  end

  logic finish;

  // Outputs
  always_comb begin
    cmd_o.req_load    = 1'b0;
    cmd_o.idx_op      = IDX_HOLD;
    cmd_o.pos_op      = POS_HOLD;
    cmd_o.rd_sel      = RD_IDX;
    cmd_o.wr_new      = 1'b0;
    cmd_o.wr_shift    = 1'b0;
    cmd_o.cnt_inc     = 1'b0;
    cmd_o.cnt_dec     = 1'b0;
    cmd_o.found_load  = 1'b0;
    cmd_o.status_load = 1'b0;
    cmd_o.status_val  = STATUS_OK;
    cmd_o.out_load    = 1'b0;
    finish            = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        cmd_o.req_load = in_valid_i;
      end
      S_DECIDE: begin
        priority if ((sts_i.op == OP_INS_PRIO || sts_i.op == OP_INS_TAIL) && sts_i.full) begin
          cmd_o.status_load = 1'b1;
          cmd_o.status_val  = STATUS_FULL;
          finish            = 1'b1;
        end else if (sts_i.op == OP_INS_TAIL || (sts_i.op == OP_INS_PRIO && sts_i.empty)) begin
          cmd_o.idx_op = IDX_COUNT;
          cmd_o.pos_op = POS_COUNT;
        end else if (sts_i.empty) begin
          cmd_o.status_load = 1'b1;
          cmd_o.status_val  = STATUS_MISSING;
          finish            = 1'b1;
        end else begin
          cmd_o.idx_op = IDX_ZERO;
        end
      end
      S_SCAN_RD: begin
        cmd_o.rd_sel = RD_IDX;
      end
      S_SCAN_CHK: begin
        priority if (sts_i.hit) begin
          if (sts_i.op == OP_INS_PRIO) begin
            cmd_o.pos_op = POS_IDX;
            cmd_o.idx_op = IDX_COUNT;
          end else begin
            cmd_o.found_load = 1'b1;
            finish           = (sts_i.op == OP_FIND);
          end
        end else if (sts_i.last) begin
          if (sts_i.op == OP_INS_PRIO) begin
            cmd_o.pos_op = POS_COUNT;
            cmd_o.idx_op = IDX_COUNT;
          end else begin
            cmd_o.status_load = 1'b1;
            cmd_o.status_val  = STATUS_MISSING;
            finish            = 1'b1;
          end
        end else begin
          cmd_o.idx_op = IDX_INC;
        end
      end
      S_SHUP_RD: begin
        cmd_o.rd_sel = RD_IDX_M1;
        if (sts_i.at_pos) begin
          finish = 1'b1;
        end
      end
      S_SHUP_WR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.idx_op   = IDX_DEC;
      end
      S_SHDN_RD: begin
        cmd_o.rd_sel = RD_IDX_P1;
        if (sts_i.last) begin
          finish = 1'b1;
        end
      end
      S_SHDN_WR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.idx_op   = IDX_INC;
      end
      default: begin
        cmd_o.req_load = 1'b0;
      end
    endcase

    // A finishing step that stalls on the output repeats; commit its side effects once
    if (finish && !sts_i.out_free) begin
      cmd_o.status_load = 1'b0;
      cmd_o.found_load  = 1'b0;
    end
    if (finish && sts_i.out_free) begin
      cmd_o.out_load = 1'b1;
      cmd_o.wr_new   = (state_q == S_SHUP_RD);
      cmd_o.cnt_inc  = (state_q == S_SHUP_RD);
      cmd_o.cnt_dec  = (state_q == S_SHDN_RD);
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.req_load |-> (state_q == S_IDLE))
    else $error("request loaded while an operation is in progress");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.wr_new && cmd_o.wr_shift))
    else $error("new entry and shift written in the same cycle");

  a_result_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> (state_q == S_IDLE))
    else $error("result issued without returning to idle");

endmodule

### tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import prq_pkg::*;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned CLK_HALF  = 5;
  localparam int unsigned GAP_MAX   = 18;
  localparam int unsigned RAND_N    = 400;
  localparam int unsigned DIR_N     = 25;
  // Leave room past the longest operation at the end.
  localparam int unsigned TAIL_WAIT = 4 * DEPTH + 40;

  // Sender pauses here until every outstanding reply is back.
  localparam int unsigned DRAIN_AT     = 200;
  // Sender offers back to back in this window.
  localparam int unsigned BURST_LO     = 250;
  localparam int unsigned BURST_HI     = 300;
  // Receiver holds off once for a long stretch so the input backs up.
  localparam int unsigned LONG_HOLD_AT = 60;
  localparam int unsigned LONG_HOLD_N  = 400;
  // Receiver takes every reply at once in this window.
  localparam int unsigned SWIFT_LO     = 300;
  localparam int unsigned SWIFT_HI     = 340;

  // One reply word: what the queue reports for one operation.
  typedef struct {
    status_e           status;
    logic [PRIO_W-1:0] found;
    logic [OCC_W-1:0]  occ;
  } queue_reply_t;

  // One directed operation; typed rows carry a reply written out by hand.
  typedef struct {
    op_e               op;
    logic [KEY_W-1:0]  key;
    logic [PRIO_W-1:0] prio;
    bit                typed;
    status_e           status;
    logic [PRIO_W-1:0] found;
    logic [OCC_W-1:0]  occ;
  } op_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [1:0]          operation_i;
  logic [KEY_W-1:0]    key_i;
  logic [PRIO_W-1:0]   priority_req_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [1:0]          status_o;
  logic [PRIO_W-1:0]   found_priority_o;
  logic [OCC_W-1:0]    occupancy_o;

  // Shadow copy of the ordered queue, head at position 0.
  logic [KEY_W-1:0]    shadow_keys  [DEPTH];
  logic [PRIO_W-1:0]   shadow_prios [DEPTH];
  int unsigned         shadow_count;

  queue_reply_t        queue_replies [$];
  op_row_t             op_rows [DIR_N];
  int unsigned         mismatches;
  int unsigned         replies_taken;

  priority_ready_queue_unit #(
    .DEPTH(DEPTH)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .key_i           (key_i),
    .priority_req_i  (priority_req_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .found_priority_o(found_priority_o),
    .occupancy_o     (occupancy_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Apply one operation to the shadow queue and return the reply it must give.
  function automatic queue_reply_t apply_queue_op(op_e op, logic [KEY_W-1:0] key,
                                                  logic [PRIO_W-1:0] prio);
    queue_reply_t r;
    int unsigned  pos;
    int unsigned  i;
    bit           hit;
    r.status = STATUS_OK;
    r.found  = '0;
    pos      = shadow_count;
    hit      = 1'b0;
    if (op == OP_INS_PRIO || op == OP_INS_TAIL) begin
      if (shadow_count >= DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        // Priority insert goes ahead of the first strictly lower priority only,
        // so equal priorities keep arrival order.
        if (op == OP_INS_PRIO) begin
          for (i = 0; i < shadow_count; i++) begin
            if (!hit && shadow_prios[i] < prio) begin
              pos = i;
              hit = 1'b1;
            end
          end
        end
        for (i = shadow_count; i > pos; i--) begin
          shadow_keys[i]  = shadow_keys[i-1];
          shadow_prios[i] = shadow_prios[i-1];
        end
        shadow_keys[pos]  = key;
        shadow_prios[pos] = prio;
        shadow_count++;
      end
    end else begin
      // Find and remove act on the match nearest the head.
      for (i = 0; i < shadow_count; i++) begin
        if (!hit && shadow_keys[i] == key) begin
          pos = i;
          hit = 1'b1;
        end
      end
      if (!hit) begin
        r.status = STATUS_MISSING;
      end else begin
        r.found = shadow_prios[pos];
        if (op == OP_REMOVE) begin
          for (i = pos; i + 1 < shadow_count; i++) begin
            shadow_keys[i]  = shadow_keys[i+1];
            shadow_prios[i] = shadow_prios[i+1];
          end
          shadow_count--;
        end
      end
    end
    r.occ = shadow_count[OCC_W-1:0];
    return r;
  endfunction

  // Offer one word after a gap, hold it until taken, then log its reply.
  // Enter and leave at a falling edge, with the previous word already taken.
  task automatic offer_word(input op_e op, input logic [KEY_W-1:0] key,
                            input logic [PRIO_W-1:0] prio, input int unsigned gap,
                            input bit typed, input queue_reply_t typed_reply);
    queue_reply_t predicted;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    key_i          <= key;
    priority_req_i <= prio;
    do @(posedge clk_i); while (in_stall_o);
    predicted = apply_queue_op(op, key, prio);
    if (typed) begin
      queue_replies.push_back(typed_reply);
    end else begin
      queue_replies.push_back(predicted);
    end
    @(negedge clk_i);
  endtask

  // Check every reply taken against the oldest one logged.
  always @(posedge clk_i) begin : reply_check
    queue_reply_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      replies_taken++;
      if (queue_replies.size() == 0) begin
        mismatches++;
        $display("%0t: reply with none outstanding: status %0d found %0d occ %0d",
                 $time, status_o, found_priority_o, occupancy_o);
      end else begin
        want = queue_replies.pop_front();
        if (status_o !== want.status) begin
          mismatches++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
        end
        if (found_priority_o !== want.found) begin
          mismatches++;
          $display("%0t: found_priority expected %0d actual %0d",
                   $time, want.found, found_priority_o);
        end
        if (occupancy_o !== want.occ) begin
          mismatches++;
          $display("%0t: occupancy expected %0d actual %0d", $time, want.occ, occupancy_o);
        end
      end
    end
  end

  // Receiver: draw a hold-off per reply, then take one word.
  initial begin : reply_sink
    int unsigned hold;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (replies_taken == LONG_HOLD_AT) begin
        hold = LONG_HOLD_N;
      end else if (replies_taken >= SWIFT_LO && replies_taken < SWIFT_HI) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, GAP_MAX);
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
      @(negedge clk_i);
    end
  end

  // Sender: reset, directed table, then random traffic, then drain and report.
  initial begin : op_source
    queue_reply_t      typed_reply;
    op_e               op;
    logic [KEY_W-1:0]  key;
    logic [PRIO_W-1:0] prio;
    int unsigned       gap;
    int unsigned       roll;
    int unsigned       n;
    int unsigned       i;
    bit                filling;

    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    operation_i    = OP_FIND;
    key_i          = '0;
    priority_req_i = '0;
    mismatches     = 0;
    replies_taken  = 0;
    shadow_count   = 0;
    for (i = 0; i < DEPTH; i++) begin
      shadow_keys[i]  = '0;
      shadow_prios[i] = '0;
    end

    // Empty queue, only entry, ties and duplicates, then fill up to full.
    op_rows = '{
      '{OP_FIND,     16'h0000, 8'h00, 1'b1, STATUS_MISSING, 8'h00, 5'd0},
      '{OP_REMOVE,   16'hFFFF, 8'hFF, 1'b1, STATUS_MISSING, 8'h00, 5'd0},
      '{OP_INS_PRIO, 16'hFFFF, 8'hFF, 1'b1, STATUS_OK,      8'h00, 5'd1},
      '{OP_REMOVE,   16'hFFFF, 8'h00, 1'b1, STATUS_OK,      8'hFF, 5'd0},
      '{OP_INS_TAIL, 16'h0000, 8'h00, 1'b1, STATUS_OK,      8'h00, 5'd1},
      '{OP_INS_PRIO, 16'h0001, 8'hFF, 1'b0, STATUS_OK,      8'h00, 5'd0},
      '{OP_INS_PRIO, 16'h0002, 8'h80, 1'b0, STATUS_OK,      8'h00, 5'd0},
      '{OP_INS_TAIL, 16'h0003, 8'hFF, 1'b0, STATUS_OK,      8'h00, 5'd0},
      '{OP_INS_PRIO, 16'h0002, 8'h10, 1'b0, STATUS_OK,      8'h00, 5'd0},
      '{OP_FIND,     16'h0002, 8'h00, 1'b0, STATUS_OK,      8'h00, 5'd0},
      '{OP_REMOVE,   16'h0002, 8'h00, 1'b0, STATUS_OK,      8'h00, 5'd0},
      '{OP_INS_PRIO, 16'h0010, 8'hFF, 1'b0, STATUS_OK,      8'h00, 5'd0},
      '{OP_INS_TAIL, 16'h0011, 8'h40, 1'b0, STATUS_OK,      8'h00, 5'd0},
      '{OP_INS_PRIO, 16'h0012, 8'h80, 1'b0, STATUS_OK,      8'h00, 5'd0},
      '{OP_INS_PRIO, 16'h0013, 8'h00, 1'b0, STATUS_OK,      8'h00, 5'd0},
      '{OP_INS_TAIL, 16'h0014, 8'hC0, 1'b0, STATUS_OK,      8'h00, 5'd0},
      '{OP_INS_PRIO, 16'h0015, 8'h7F, 1'b0, STATUS_OK,      8'h00, 5'd0},
      '{OP_INS_PRIO, 16'h0016, 8'h01, 1'b0, STATUS_OK,      8'h00, 5'd0},
      '{OP_INS_TAIL, 16'h0017, 8'hFE, 1'b0, STATUS_OK,      8'h00, 5'd0},
      '{OP_INS_PRIO, 16'h0018, 8'h80, 1'b0, STATUS_OK,      8'h00, 5'd0},
      '{OP_INS_PRIO, 16'h0019, 8'hFF, 1'b0, STATUS_OK,      8'h00, 5'd0},
      '{OP_INS_TAIL, 16'h001A, 8'h00, 1'b0, STATUS_OK,      8'h00, 5'd0},
      '{OP_INS_PRIO, 16'h001B, 8'h55, 1'b0, STATUS_OK,      8'h00, 5'd0},
      '{OP_INS_PRIO, 16'hAAAA, 8'hFF, 1'b1, STATUS_FULL,    8'h00, 5'd16},
      '{OP_INS_TAIL, 16'h5555, 8'h00, 1'b1, STATUS_FULL,    8'h00, 5'd16}
    };

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (i = 0; i < DIR_N; i++) begin
      typed_reply.status = op_rows[i].status;
      typed_reply.found  = op_rows[i].found;
      typed_reply.occ    = op_rows[i].occ;
      offer_word(op_rows[i].op, op_rows[i].key, op_rows[i].prio,
                 $urandom_range(0, GAP_MAX), op_rows[i].typed, typed_reply);
    end

    // Alternate fill-heavy and drain-heavy stretches so the queue swings
    // between empty and full. Find and remove mostly target live keys.
    for (n = 0; n < RAND_N; n++) begin
      if (n == DRAIN_AT) begin
        in_valid_i <= 1'b0;
        while (queue_replies.size() != 0) @(posedge clk_i);
        @(negedge clk_i);
      end
      filling = ((n / 40) % 2) == 0;
      roll    = $urandom_range(0, 99);
      if (filling) begin
        op = (roll < 45) ? OP_INS_PRIO : (roll < 75) ? OP_INS_TAIL :
             (roll < 85) ? OP_FIND : OP_REMOVE;
      end else begin
        op = (roll < 12) ? OP_INS_PRIO : (roll < 20) ? OP_INS_TAIL :
             (roll < 40) ? OP_FIND : OP_REMOVE;
      end

      roll = $urandom_range(0, 9);
      if ((op == OP_FIND || op == OP_REMOVE) && shadow_count > 0 && roll < 8) begin
        key = shadow_keys[$urandom_range(0, shadow_count - 1)];
      end else if (roll < 7) begin
        // Small key pool: plenty of duplicates.
        key = KEY_W'($urandom_range(0, 15));
      end else begin
        key = KEY_W'($urandom_range(0, 16'hFFFF));
      end

      roll = $urandom_range(0, 7);
      if (roll == 0) begin
        prio = '0;
      end else if (roll == 1) begin
        prio = '1;
      end else if (roll < 4 && shadow_count > 0) begin
        // Tie with a priority already queued.
        prio = shadow_prios[$urandom_range(0, shadow_count - 1)];
      end else begin
        prio = PRIO_W'($urandom_range(0, 8'hFF));
      end

      if (n >= BURST_LO && n < BURST_HI) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, GAP_MAX);
      end
      offer_word(op, key, prio, gap, 1'b0, typed_reply);
    end

    in_valid_i <= 1'b0;
    while (queue_replies.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin : watchdog
    #(2_000_000);
    $display("TEST FAILED");
    $finish;
  end

endmodule
